// File: hdl/rhps_pkg.sv
`default_nettype none
package rhps_pkg;

  // Fixed widths of the request, result and configuration fields
  localparam int unsigned PulseW   = 16;
  localparam int unsigned RangeW   = 16;
  localparam int unsigned HeadingW = 12;
  localparam int unsigned GainW    = 16;
  localparam int unsigned CfgIdxW  = 3;

  // Internal arithmetic widths
  localparam int unsigned MerrW = RangeW + 1;       // 100 - range, signed
  localparam int unsigned HerrW = HeadingW + 1;     // wrapped heading error, signed
  localparam int unsigned ProdW = GainW + MerrW;    // widest product
  localparam int unsigned QuotW = ProdW - 8;        // product / 256
  localparam int unsigned ReqW  = QuotW + 1;        // center + quotient

  // Control constants
  localparam logic [RangeW-1:0]   SearchRange = 16'd1500;
  localparam logic [RangeW-1:0]   TargetRange = 16'd100;
  localparam logic [HeadingW-1:0] HalfTurn    = 12'd1800;
  localparam logic [HeadingW-1:0] FullTurn    = 12'd3600;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOT_MID      = 3'd0,
    CFG_MOT_LO       = 3'd1,
    CFG_MOT_HI       = 3'd2,
    CFG_SRV_MID      = 3'd3,
    CFG_SRV_LO       = 3'd4,
    CFG_SRV_HI       = 3'd5,
    CFG_MOTOR_GAIN   = 3'd6,
    CFG_SERVO_GAIN   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [PulseW-1:0]       mot_mid;
    logic [PulseW-1:0]       mot_lo;
    logic [PulseW-1:0]       mot_hi;
    logic [PulseW-1:0]       srv_mid;
    logic [PulseW-1:0]       srv_lo;
    logic [PulseW-1:0]       srv_hi;
    logic signed [GainW-1:0] motor_gain;
    logic signed [GainW-1:0] servo_gain;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    mot_mid:      16'd2765,
    mot_lo:       16'd2028,
    mot_hi:       16'd3502,
    srv_mid:      16'd2765,
    srv_lo:       16'd1659,
    srv_hi:       16'd3871,
    motor_gain:   -16'sd3494,
    servo_gain:   16'sd960
  };

  // Limits applied to one pulse channel
  typedef struct packed {
    logic [PulseW-1:0] center;
    logic [PulseW-1:0] lo;
    logic [PulseW-1:0] hi;
    logic [PulseW-1:0] search_val;
  } lim_t;

endpackage
`default_nettype wire

// File: hdl/rhps_in_if.sv
`default_nettype none
interface rhps_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_cm;
  logic [11:0] heading_tenths;
  logic        motor_stop;
  logic        steer_center;

  modport source (output valid, output range_cm, output heading_tenths,
                  output motor_stop, output steer_center, input ready);
  modport sink   (input valid, input range_cm, input heading_tenths,
                  input motor_stop, input steer_center, output ready);
endinterface
`default_nettype wire

// File: hdl/rhps_out_if.sv
`default_nettype none
interface rhps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] motor_pulse;
  logic [15:0] servo_pulse;
  logic        searching;

  modport source (output valid, output motor_pulse, output servo_pulse,
                  output searching, input ready);
  modport sink   (input valid, input motor_pulse, input servo_pulse,
                  input searching, output ready);
endinterface
`default_nettype wire

// File: hdl/range_heading_proportional_steer_top.sv
`default_nettype none
// Proportional speed and steering controller with saturation.
//
// in_if carries one request: range in cm, compass heading in tenths of a
// degree and two override switches. out_if returns one result per request:
// motor and servo pulse widths and the search flag. Both channels use a
// valid/ready handshake; a request moves on a rising edge with both high.
// The cfg port writes one of eight 16-bit registers at each edge with
// cfg_we high (cfg_idx selects it); write only while the block is empty.
//
// Pipeline: three registers (input, product, result). An accepted request
// passes the input, product and result registers in turn to out_if.
// Throughput: one request per cycle unless out_if.ready is held low; the
// gain multipliers between the input and product registers set the clock period.
// Reset clears all pipeline valid flags and loads the default gains and
// pulse limits. When the receiver holds out_if.ready low, the result is
// held and the upstream stages keep filling until all three are occupied,
// after which in_if.ready drops.
module range_heading_proportional_steer_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rhps_in_if.sink                           in_if,
  rhps_out_if.source                        out_if,
  input  wire logic                         cfg_we,
  input  wire logic [rhps_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [rhps_pkg::PulseW-1:0]  cfg_data
);
  import rhps_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // input stage
  logic                a_v_r, a_v_nxt;
  logic [RangeW-1:0]   a_range_r;
  logic [HeadingW-1:0] a_heading_r;
  logic                a_mstop_r, a_scenter_r;

  // product stage
  logic                    b_v_r, b_v_nxt;
  logic signed [ProdW-1:0] b_mprod_r, b_sprod_r;
  logic                    b_search_r, b_mstop_r, b_scenter_r;

  // result stage
  logic              o_v_r, o_v_nxt;
  logic [PulseW-1:0] o_motor_r, o_servo_r;
  logic              o_search_r;

  logic en_o, en_b, en_a;
  logic signed [MerrW-1:0] merr;
  logic signed [HerrW-1:0] herr_wrap, herr;
  logic                    search;
  logic [PulseW-1:0]       motor_pulse, servo_pulse;
  lim_t                    motor_lim, servo_lim;

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_MOT_MID:      cfg_nxt.mot_mid      = cfg_data;
        CFG_MOT_LO:       cfg_nxt.mot_lo       = cfg_data;
        CFG_MOT_HI:       cfg_nxt.mot_hi       = cfg_data;
        CFG_SRV_MID:      cfg_nxt.srv_mid      = cfg_data;
        CFG_SRV_LO:       cfg_nxt.srv_lo       = cfg_data;
        CFG_SRV_HI:       cfg_nxt.srv_hi       = cfg_data;
        CFG_MOTOR_GAIN:   cfg_nxt.motor_gain   = $signed(cfg_data);
        CFG_SERVO_GAIN:   cfg_nxt.servo_gain   = $signed(cfg_data);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage enables: a stage advances when it is empty or the next one advances
  assign en_o = !o_v_r || out_if.ready;
  assign en_b = !b_v_r || en_o;
  assign en_a = !a_v_r || en_b;
  assign in_if.ready = en_a;

  assign a_v_nxt = en_a ? in_if.valid : a_v_r;
  assign b_v_nxt = en_b ? a_v_r : b_v_r;
  assign o_v_nxt = en_o ? b_v_r : o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_range_r   <= in_if.range_cm;
      a_heading_r <= in_if.heading_tenths;
      a_mstop_r   <= in_if.motor_stop;
      a_scenter_r <= in_if.steer_center;
    end
  end

  // Range and heading errors
  always_comb begin
    search = a_range_r > SearchRange;
    merr   = $signed({1'b0, TargetRange}) - $signed({1'b0, a_range_r});
    if (a_heading_r > HalfTurn) begin
      herr_wrap = $signed({1'b0, FullTurn}) - $signed({1'b0, a_heading_r});
    end else begin
      herr_wrap = -$signed({1'b0, a_heading_r});
    end
    herr = (a_range_r < TargetRange) ? -herr_wrap : herr_wrap;
  end

  // Multiply errors by gains
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_mprod_r   <= ProdW'(cfg_r.motor_gain) * ProdW'(merr);
      b_sprod_r   <= ProdW'(cfg_r.servo_gain) * ProdW'(herr);
      b_search_r  <= search;
      b_mstop_r   <= a_mstop_r;
      b_scenter_r <= a_scenter_r;
    end
  end

  // Scale, clamp and override each channel
  always_comb begin
    motor_lim.center     = cfg_r.mot_mid;
    motor_lim.lo         = cfg_r.mot_lo;
    motor_lim.hi         = cfg_r.mot_hi;
    motor_lim.search_val = cfg_r.mot_hi;
    servo_lim.center     = cfg_r.srv_mid;
    servo_lim.lo         = cfg_r.srv_lo;
    servo_lim.hi         = cfg_r.srv_hi;
    servo_lim.search_val = cfg_r.srv_lo;
  end

  rhps_sat u_motor_sat (
    .prod         (b_mprod_r),
    .search       (b_search_r),
    .force_center (b_mstop_r),
    .lim          (motor_lim),
    .pulse        (motor_pulse)
  );

  rhps_sat u_servo_sat (
    .prod         (b_sprod_r),
    .search       (b_search_r),
    .force_center (b_scenter_r),
    .lim          (servo_lim),
    .pulse        (servo_pulse)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (en_o) begin
      o_motor_r  <= motor_pulse;
      o_servo_r  <= servo_pulse;
      o_search_r <= b_search_r;
    end
  end

  assign out_if.valid       = o_v_r;
  assign out_if.motor_pulse = o_motor_r;
  assign out_if.servo_pulse = o_servo_r;
  assign out_if.searching   = o_search_r;

  // Input stalls only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (a_v_r && b_v_r && o_v_r))
    else $error("input stalled with a free stage");

  // A request in the input stage moves on when the product stage frees up
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && en_b) |=> b_v_r)
    else $error("request lost between input and product stages");

  // Search results drive the motor to max, or to min/center by clamp or override
  a_search_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_search_r) |-> (o_motor_r == cfg_r.mot_hi ||
                               o_motor_r == cfg_r.mot_lo ||
                               o_motor_r == cfg_r.mot_mid))
    else $error("search mode motor pulse off limits");

  // Servo stays inside its limits unless forced to center, when srv_lo <= srv_hi
  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && cfg_r.srv_lo <= cfg_r.srv_hi) |->
      ((o_servo_r >= cfg_r.srv_lo && o_servo_r <= cfg_r.srv_hi) ||
       o_servo_r == cfg_r.srv_mid))
    else $error("servo pulse outside limits");

endmodule
`default_nettype wire

// File: hdl/rhps_sat.sv
`default_nettype none
module rhps_sat (
  input  wire logic signed [rhps_pkg::ProdW-1:0] prod,
  input  wire logic                              search,
  input  wire logic                              force_center,
  input  wire rhps_pkg::lim_t                    lim,
  output logic [rhps_pkg::PulseW-1:0]            pulse
);
  import rhps_pkg::*;

  logic signed [ProdW-1:0] biased;
  logic signed [QuotW-1:0] quot;
  logic signed [ReqW-1:0]  req;
  logic signed [ReqW-1:0]  lo_s;
  logic signed [ReqW-1:0]  hi_s;
  logic [PulseW-1:0]       clamped;

  // Divide by 256 rounding toward zero: bias negative products first
  always_comb begin
    biased = prod + (prod[ProdW-1] ? ProdW'(255) : ProdW'(0));
    quot   = biased[ProdW-1:8];
  end

  // Form the request: search value or center plus scaled error
  always_comb begin
    if (search) begin
      req = $signed({{(ReqW-PulseW){1'b0}}, lim.search_val});
    end else begin
      req = $signed({{(ReqW-PulseW){1'b0}}, lim.center}) + $signed({quot[QuotW-1], quot});
    end
  end

  // Clamp, max test first, then override to center
  always_comb begin
    lo_s = $signed({{(ReqW-PulseW){1'b0}}, lim.lo});
    hi_s = $signed({{(ReqW-PulseW){1'b0}}, lim.hi});
    priority if (req > hi_s) begin
      clamped = lim.hi;
    end else if (req < lo_s) begin
      clamped = lim.lo;
    end else begin
      clamped = req[PulseW-1:0];
    end
    pulse = force_center ? lim.center : clamped;
  end

endmodule
`default_nettype wire
